@@ design/lls_pkg.sv @@
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types and constants of the least-load selector.
// ----------------------------------------------------------------------------
package lls_pkg;

    // Fixed field widths of the request and result items
    localparam int CNT_BITS = 4;   // candidate_count, tie_size
    localparam int IDX_BITS = 3;   // chosen_index

    // policy_mode codes
    localparam logic MODE_RR = 1'b0;
    localparam logic MODE_LL = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LANE,
        S_MERGE,
        S_PICK
    } t_state;

    // Tie summary from the merge stage
    typedef struct packed {
        logic [CNT_BITS-1:0] size;
        logic [IDX_BITS-1:0] idx;
    } t_tie_info;

endpackage

@@ design/lls_req_if.sv @@
// ----------------------------------------------------------------------------
// lls_req_if
// Request channel: candidate count and one load per candidate.
// ----------------------------------------------------------------------------
interface lls_req_if #(
    parameter int MAX_CANDIDATES = 8,
    parameter int LOAD_BITS      = 16
);
    logic                                      valid;
    logic                                      ready;
    logic [lls_pkg::CNT_BITS-1:0]              candidate_count;
    logic [MAX_CANDIDATES-1:0][LOAD_BITS-1:0]  load;

    modport source (output valid, output candidate_count, output load, input ready);
    modport sink   (input valid, input candidate_count, input load, output ready);
endinterface

@@ design/lls_res_if.sv @@
// ----------------------------------------------------------------------------
// lls_res_if
// Result channel: chosen candidate and tie summary.
// ----------------------------------------------------------------------------
interface lls_res_if #(
    parameter int LOAD_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [lls_pkg::IDX_BITS-1:0]  chosen_index;
    logic                          no_choice;
    logic [LOAD_BITS-1:0]          least_load;
    logic [lls_pkg::CNT_BITS-1:0]  tie_size;

    modport source (output valid, output chosen_index, output no_choice,
                    output least_load, output tie_size, input ready);
    modport sink   (input valid, input chosen_index, input no_choice,
                    input least_load, input tie_size, output ready);
endinterface

@@ design/least_load_selector.sv @@
// ----------------------------------------------------------------------------
// least_load_selector
// Picks one target per request by least load with rotating tie break, or
// by plain round robin.
// ----------------------------------------------------------------------------
// Each request item passes through capture, a lane compare in which every
// candidate lane checks itself against all others in parallel, a merge that
// counts the ties and finds the minimum load, and the pick. The pick is set
// by the merge-to-pick path, one item at a time through the sequencer; the
// result sits in an output register so the next request is taken while the
// previous result waits. Both counters keep their residues modulo every
// candidate count, so the modulo needs no divider. policy_mode resets to
// least-load mode.
module least_load_selector #(
    parameter int MAX_CANDIDATES = 8,
    parameter int LOAD_BITS      = 16,
    parameter int COUNTER_BITS   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    lls_req_if.sink           i_req,
    lls_res_if.source         o_res
);
    import lls_pkg::*;

    localparam int RES_BITS = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

    t_state                                  r_state, n_state;
    logic                                    r_mode;
    logic [CNT_BITS-1:0]                     r_n;
    logic [MAX_CANDIDATES-1:0][LOAD_BITS-1:0] r_loads;
    logic [MAX_CANDIDATES-1:0]               r_tie_mask;
    logic [CNT_BITS-1:0]                     r_tie_cnt;
    logic [LOAD_BITS-1:0]                    r_min;

    logic                                    r_out_valid;
    logic [IDX_BITS-1:0]                     r_out_idx;
    logic                                    r_out_none;
    logic [LOAD_BITS-1:0]                    r_out_load;
    logic [CNT_BITS-1:0]                     r_out_ties;

    logic [MAX_CANDIDATES-1:0]               valid_mask;
    logic [MAX_CANDIDATES-1:0]               lane_min;
    logic [MAX_CANDIDATES-1:0]               pick_hit;
    t_tie_info                               tie_info;
    logic [LOAD_BITS-1:0]                    min_load;
    logic [MAX_CANDIDATES-1:0][RES_BITS-1:0] rot_res;
    logic [MAX_CANDIDATES-1:0][RES_BITS-1:0] tie_res;
    logic [CNT_BITS-1:0]                     n_minus1;
    logic [CNT_BITS-1:0]                     ties_minus1;
    logic [CNT_BITS-1:0]                     cnt_sat;
    logic                                    accept;
    logic                                    pick_go;
    logic                                    rot_step;
    logic                                    tie_step;

    // Handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign pick_go     = (r_state == S_PICK) && (!r_out_valid || o_res.ready);

    // Saturate the candidate count at the lane count
    assign cnt_sat = (i_req.candidate_count > CNT_BITS'(MAX_CANDIDATES))
                   ? CNT_BITS'(MAX_CANDIDATES) : i_req.candidate_count;

    // Lanes taking part in this item
    always_comb begin
        for (int i = 0; i < MAX_CANDIDATES; i++) begin
            valid_mask[i] = (CNT_BITS'(i) < r_n);
        end
    end

    // Candidate lanes
    for (genvar g = 0; g < MAX_CANDIDATES; g++) begin : g_lane
        lls_lane #(
            .MAX_CANDIDATES (MAX_CANDIDATES),
            .LOAD_BITS      (LOAD_BITS),
            .LANE           (g)
        ) u_lane (
            .i_loads  (r_loads),
            .i_valid  (valid_mask),
            .o_is_min (lane_min[g])
        );
    end

    // Merge of the lane flags; rank comes from the tie counter residues
    assign ties_minus1 = r_tie_cnt - 1'b1;
    assign n_minus1    = r_n - 1'b1;

    lls_merge #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .LOAD_BITS      (LOAD_BITS)
    ) u_merge (
        .i_tie_mask (r_tie_mask),
        .i_loads    (r_loads),
        .i_sel      (tie_res[ties_minus1[RES_BITS-1:0]]),
        .o_info     (tie_info),
        .o_min_load (min_load),
        .o_pick_hit (pick_hit)
    );

    // Counters; only the active mode's counter moves, never with no candidates
    assign rot_step = pick_go && (r_n != '0) && (r_mode == MODE_RR);
    assign tie_step = pick_go && (r_n != '0) && (r_mode == MODE_LL);

    lls_res_cnt #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COUNTER_BITS   (COUNTER_BITS)
    ) u_rot_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (rot_step),
        .o_res   (rot_res)
    );

    lls_res_cnt #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COUNTER_BITS   (COUNTER_BITS)
    ) u_tie_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (tie_step),
        .o_res   (tie_res)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LL;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_LANE;
            S_LANE:  n_state = S_MERGE;
            S_MERGE: n_state = S_PICK;
            S_PICK:  if (pick_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Item capture and per-stage working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n     <= cnt_sat;
            r_loads <= i_req.load;
        end
        if (r_state == S_LANE) begin
            r_tie_mask <= lane_min;
        end
        if (r_state == S_MERGE) begin
            r_tie_cnt <= tie_info.size;
            r_min     <= min_load;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pick_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pick_go) begin
            if (r_n == '0) begin
                r_out_idx  <= '0;
                r_out_none <= 1'b1;
                r_out_load <= '0;
                r_out_ties <= '0;
            end else if (r_mode == MODE_RR) begin
                r_out_idx  <= IDX_BITS'(rot_res[n_minus1[RES_BITS-1:0]]);
                r_out_none <= 1'b0;
                r_out_load <= '0;
                r_out_ties <= '0;
            end else begin
                r_out_idx  <= tie_info.idx;
                r_out_none <= 1'b0;
                r_out_load <= r_min;
                r_out_ties <= r_tie_cnt;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.chosen_index = r_out_idx;
    assign o_res.no_choice    = r_out_none;
    assign o_res.least_load   = r_out_load;
    assign o_res.tie_size     = r_out_ties;

    // With candidates present, least-load mode always has at least one tie
    a_tie_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_n != '0 && r_mode == MODE_LL)
        |-> (r_tie_cnt != '0 && r_tie_cnt <= r_n))
        else $error("tie count out of range at pick");

    // Exactly one tied lane is selected
    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_n != '0 && r_mode == MODE_LL) |-> $onehot(pick_hit))
        else $error("tie pick not one-hot");

    // The round-robin counter holds across a least-load pick
    a_rot_isolated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pick_go && r_mode == MODE_LL) |=> $stable(rot_res))
        else $error("rotation counter moved in least-load mode");

    // No new item is taken between capture and pick
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LANE || r_state == S_MERGE) |-> !i_req.ready)
        else $error("request taken while an item is in flight");

endmodule

@@ design/lls_lane.sv @@
// ----------------------------------------------------------------------------
// lls_lane
// One candidate lane: flags whether its load is a minimum of the valid set.
// ----------------------------------------------------------------------------
module lls_lane #(
    parameter int MAX_CANDIDATES = 8,
    parameter int LOAD_BITS      = 16,
    parameter int LANE           = 0
) (
    input  logic [MAX_CANDIDATES-1:0][LOAD_BITS-1:0] i_loads,
    input  logic [MAX_CANDIDATES-1:0]                i_valid,
    output logic                                     o_is_min
);
    import lls_pkg::*;

    // Minimum if no other valid lane holds a strictly smaller load
    always_comb begin
        o_is_min = i_valid[LANE];
        for (int j = 0; j < MAX_CANDIDATES; j++) begin
            if (i_valid[j] && (i_loads[j] < i_loads[LANE])) begin
                o_is_min = 1'b0;
            end
        end
    end

endmodule

@@ design/lls_merge.sv @@
// ----------------------------------------------------------------------------
// lls_merge
// Merges lane flags: tie count, minimum load and the selected tie entry.
// ----------------------------------------------------------------------------
module lls_merge #(
    parameter int MAX_CANDIDATES = 8,
    parameter int LOAD_BITS      = 16,
    localparam int RES_BITS      = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1
) (
    input  logic [MAX_CANDIDATES-1:0]                i_tie_mask,
    input  logic [MAX_CANDIDATES-1:0][LOAD_BITS-1:0] i_loads,
    input  logic [RES_BITS-1:0]                      i_sel,
    output lls_pkg::t_tie_info                       o_info,
    output logic [MAX_CANDIDATES-1:0]                o_pick_hit,
    output logic [LOAD_BITS-1:0]                     o_min_load
);
    import lls_pkg::*;

    logic [CNT_BITS-1:0] run;

    // Load of the lowest tied lane; selected tie entry is the lane whose
    // rank among the ties equals i_sel; the final rank is the tie count
    always_comb begin
        o_info     = '0;
        o_min_load = '0;
        o_pick_hit = '0;
        run        = '0;
        for (int i = MAX_CANDIDATES - 1; i >= 0; i--) begin
            if (i_tie_mask[i]) begin
                o_min_load = i_loads[i];
            end
        end
        for (int i = 0; i < MAX_CANDIDATES; i++) begin
            if (i_tie_mask[i] && (run == CNT_BITS'(i_sel))) begin
                o_pick_hit[i] = 1'b1;
                o_info.idx    = IDX_BITS'(i);
            end
            run = run + CNT_BITS'(i_tie_mask[i]);
        end
        o_info.size = run;
    end

endmodule

@@ design/lls_res_cnt.sv @@
// ----------------------------------------------------------------------------
// lls_res_cnt
// Wrapping counter that also keeps its residue modulo 1..MAX_CANDIDATES.
// ----------------------------------------------------------------------------
module lls_res_cnt #(
    parameter int MAX_CANDIDATES = 8,
    parameter int COUNTER_BITS   = 32,
    localparam int RES_BITS      = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_step,
    output logic [MAX_CANDIDATES-1:0][RES_BITS-1:0] o_res
);
    import lls_pkg::*;

    logic [COUNTER_BITS-1:0]                 r_count;
    logic [MAX_CANDIDATES-1:0][RES_BITS-1:0] r_res;

    // Entry k holds count mod (k+1); all clear again when the count wraps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_res   <= '0;
        end else if (i_step) begin
            if (&r_count) begin
                r_count <= '0;
                r_res   <= '0;
            end else begin
                r_count <= r_count + 1'b1;
                for (int k = 0; k < MAX_CANDIDATES; k++) begin
                    if (r_res[k] == RES_BITS'(k)) begin
                        r_res[k] <= '0;
                    end else begin
                        r_res[k] <= r_res[k] + 1'b1;
                    end
                end
            end
        end
    end

    assign o_res = r_res;

endmodule
